### hdl/hsh_pkg.sv
// Shared constants, payload types and codes for the hue shift pipeline.
package hsh_pkg;

  localparam int CHANNEL_BITS      = 8;
  localparam int HUE_FRACTION_BITS = 8;

  // Hue values run 0..6*ONE-1, so three integer bits above the fraction.
  localparam int HUE_W     = HUE_FRACTION_BITS + 3;
  // Quotient of |diff|*ONE/d is at most ONE.
  localparam int QUO_W     = HUE_FRACTION_BITS + 1;
  localparam int DIV_STEPS  = 3;
  localparam int DIV_STAGES = (QUO_W + DIV_STEPS - 1) / DIV_STEPS;
  localparam int DIV_TOTAL  = DIV_STAGES * DIV_STEPS;
  localparam int DIV_EXTRA  = DIV_TOTAL - QUO_W;
  localparam int KW         = HUE_FRACTION_BITS + 1;

  localparam logic [HUE_W-1:0] HUE_ONE  = HUE_W'(1 << HUE_FRACTION_BITS);
  localparam logic [HUE_W-1:0] HUE_TURN = HUE_W'(6 << HUE_FRACTION_BITS);

  typedef logic [CHANNEL_BITS-1:0] chan_t;
  typedef logic [CHANNEL_BITS:0]   cand_t;
  typedef logic [DIV_TOTAL-1:0]    qdiv_t;
  typedef logic [HUE_W-1:0]        hue_val_t;
  typedef logic [KW-1:0]           kval_t;

  typedef enum logic [1:0] {
    SEC_RED   = 2'd0,
    SEC_GREEN = 2'd1,
    SEC_BLUE  = 2'd2
  } sec_t;

  typedef struct packed {
    chan_t alpha;
    chan_t vmax;
    chan_t d;
    sec_t  sec;
    logic  neg;
  } ctx_t;

  typedef struct packed {
    ctx_t  ctx;
    cand_t cand;
    qdiv_t q;
  } div_t;

  typedef struct packed {
    chan_t    alpha;
    chan_t    vmax;
    chan_t    d;
    hue_val_t hue;
  } hue_t;

endpackage

### hdl/hsh_ifs.sv
// Valid/ready channel interfaces for the pixel input and the pixel result.
interface hsh_in_if import hsh_pkg::*; ();
  logic  valid;
  logic  ready;
  chan_t red_in;
  chan_t green_in;
  chan_t blue_in;
  chan_t alpha_in;

  modport source (output valid, output red_in, output green_in, output blue_in,
                  output alpha_in, input ready);
  modport sink (input valid, input red_in, input green_in, input blue_in,
                input alpha_in, output ready);
endinterface

interface hsh_out_if import hsh_pkg::*; ();
  logic  valid;
  logic  ready;
  chan_t red_out;
  chan_t green_out;
  chan_t blue_out;
  chan_t alpha_out;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  output alpha_out, input ready);
  modport sink (input valid, input red_out, input green_out, input blue_out,
                input alpha_out, output ready);
endinterface

### hdl/hsh_analyze.sv
// First stage: max, min, chroma, hue sector and the divider's starting operand.
module hsh_analyze import hsh_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  hsh_in_if.sink        in_ch,
  output logic          dn_valid,
  input  logic          dn_ready,
  output div_t          dn_data
);

  logic  v_r;
  div_t  data_r;
  div_t  data_nxt;
  chan_t vmax;
  chan_t vmin;
  chan_t x;
  chan_t y;
  sec_t  sec;

  assign in_ch.ready = !v_r || dn_ready;
  assign dn_valid    = v_r;
  assign dn_data     = data_r;

  always_comb begin
    vmax = in_ch.red_in;
    vmin = in_ch.red_in;
    if (in_ch.green_in > vmax) vmax = in_ch.green_in;
    if (in_ch.blue_in > vmax) vmax = in_ch.blue_in;
    if (in_ch.green_in < vmin) vmin = in_ch.green_in;
    if (in_ch.blue_in < vmin) vmin = in_ch.blue_in;

    // Ties resolve red first, then green, then blue.
    if (in_ch.red_in >= vmax) begin
      sec = SEC_RED;
    end else if (in_ch.green_in >= vmax) begin
      sec = SEC_GREEN;
    end else begin
      sec = SEC_BLUE;
    end

    case (sec)
      SEC_RED: begin
        x = in_ch.green_in;
        y = in_ch.blue_in;
      end
      SEC_GREEN: begin
        x = in_ch.blue_in;
        y = in_ch.red_in;
      end
      SEC_BLUE: begin
        x = in_ch.red_in;
        y = in_ch.green_in;
      end
      default: begin
        x = in_ch.red_in;
        y = in_ch.green_in;
      end
    endcase

    data_nxt.ctx.alpha = in_ch.alpha_in;
    data_nxt.ctx.vmax  = vmax;
    data_nxt.ctx.d     = vmax - vmin;
    data_nxt.ctx.sec   = sec;
    data_nxt.ctx.neg   = x < y;
    data_nxt.cand      = (x >= y) ? {1'b0, x - y} : {1'b0, y - x};
    data_nxt.q         = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ch.ready) begin
      v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

### hdl/hsh_div_stage.sv
// One pipelined slice of the restoring divider: a few quotient bits per stage.
module hsh_div_stage import hsh_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic up_valid,
  output logic up_ready,
  input  div_t up_data,
  output logic dn_valid,
  input  logic dn_ready,
  output div_t dn_data
);

  logic v_r;
  div_t data_r;
  div_t data_nxt;

  assign up_ready = !v_r || dn_ready;
  assign dn_valid = v_r;
  assign dn_data  = data_r;

  // The candidate is the partial remainder already shifted left, so every
  // step is a compare, an optional subtract and a shift.
  always_comb begin : steps
    cand_t rem;
    logic  qbit;
    data_nxt = up_data;
    for (int i = 0; i < DIV_STEPS; i++) begin
      if (data_nxt.cand >= {1'b0, data_nxt.ctx.d}) begin
        rem  = data_nxt.cand - {1'b0, data_nxt.ctx.d};
        qbit = 1'b1;
      end else begin
        rem  = data_nxt.cand;
        qbit = 1'b0;
      end
      data_nxt.cand = {rem[CHANNEL_BITS-1:0], 1'b0};
      data_nxt.q    = {data_nxt.q[DIV_TOTAL-2:0], qbit};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

### hdl/hsh_hue.sv
// Two stages: assemble the pixel hue from the quotient, then add the offset.
module hsh_hue import hsh_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  hue_val_t shift,
  input  logic     up_valid,
  output logic     up_ready,
  input  div_t     up_data,
  output logic     dn_valid,
  input  logic     dn_ready,
  output hue_t     dn_data
);

  logic               e_v_r;
  hue_t               e_r;
  hue_t               e_nxt;
  logic               f_v_r;
  hue_t               f_r;
  hue_t               f_nxt;
  logic               e_ready;
  logic [QUO_W-1:0]   q;
  logic               rnz;
  logic [QUO_W:0]     qm;
  logic [HUE_W:0]     qext;
  logic [HUE_W-1:0]   base;
  logic [HUE_W:0]     hs;
  logic [HUE_W:0]     sum;

  assign e_ready  = !f_v_r || dn_ready;
  assign up_ready = !e_v_r || e_ready;
  assign dn_valid = f_v_r;
  assign dn_data  = f_r;

  always_comb begin
    // Extra low quotient bits, if any, only feed the floor correction.
    q   = QUO_W'(up_data.q >> DIV_EXTRA);
    rnz = (up_data.cand != '0) ||
          ((up_data.q & DIV_TOTAL'((1 << DIV_EXTRA) - 1)) != '0);
    // A negative difference rounds toward minus infinity.
    qm   = {1'b0, q} + (QUO_W + 1)'(up_data.ctx.neg && rnz);
    qext = {{(HUE_W - QUO_W){1'b0}}, qm};

    case (up_data.ctx.sec)
      SEC_RED:   base = '0;
      SEC_GREEN: base = HUE_ONE << 1;
      SEC_BLUE:  base = HUE_ONE << 2;
      default:   base = '0;
    endcase

    hs = up_data.ctx.neg ? ({1'b0, base} - qext) : ({1'b0, base} + qext);

    e_nxt.alpha = up_data.ctx.alpha;
    e_nxt.vmax  = up_data.ctx.vmax;
    e_nxt.d     = up_data.ctx.d;
    e_nxt.hue   = hs[HUE_W] ? (hs[HUE_W-1:0] + HUE_TURN) : hs[HUE_W-1:0];
  end

  always_comb begin
    sum       = {1'b0, e_r.hue} + {1'b0, shift};
    f_nxt     = e_r;
    f_nxt.hue = (sum >= {1'b0, HUE_TURN}) ? HUE_W'(sum - {1'b0, HUE_TURN})
                                          : sum[HUE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v_r <= 1'b0;
      f_v_r <= 1'b0;
    end else begin
      if (up_ready) begin
        e_v_r <= up_valid;
      end
      if (e_ready) begin
        f_v_r <= e_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      e_r <= e_nxt;
    end
    if (e_ready && e_v_r) begin
      f_r <= f_nxt;
    end
  end

endmodule

### hdl/hsh_rebuild.sv
// Two stages: per-channel weight from the shifted hue, then value minus scaled chroma.
module hsh_rebuild import hsh_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      up_valid,
  output logic      up_ready,
  input  hue_t      up_data,
  hsh_out_if.source out_ch
);

  localparam logic [HUE_W:0] OFF_RED   = (HUE_W + 1)'(5 << HUE_FRACTION_BITS);
  localparam logic [HUE_W:0] OFF_GREEN = (HUE_W + 1)'(3 << HUE_FRACTION_BITS);
  localparam logic [HUE_W:0] OFF_BLUE  = (HUE_W + 1)'(1 << HUE_FRACTION_BITS);

  typedef struct packed {
    chan_t alpha;
    chan_t vmax;
    chan_t d;
    kval_t kr;
    kval_t kg;
    kval_t kb;
  } wgt_t;

  logic g_v_r;
  wgt_t g_r;
  wgt_t g_nxt;
  logic g_ready;
  logic o_v_r;
  chan_t red_r;
  chan_t green_r;
  chan_t blue_r;
  chan_t alpha_r;
  chan_t red_nxt;
  chan_t green_nxt;
  chan_t blue_nxt;

  // k = clamp(min(m, 4*ONE - m), 0, ONE) with m = (offset + hue) mod turn.
  function automatic kval_t chan_weight(input hue_val_t hue, input logic [HUE_W:0] off);
    logic [HUE_W:0]   msum;
    logic [HUE_W-1:0] m;
    logic [HUE_W-1:0] t;
    logic [HUE_W-1:0] kk;
    msum = {1'b0, hue} + off;
    m = (msum >= {1'b0, HUE_TURN}) ? HUE_W'(msum - {1'b0, HUE_TURN}) : msum[HUE_W-1:0];
    if (m > (HUE_ONE << 2)) begin
      kk = '0;
    end else begin
      t  = (HUE_ONE << 2) - m;
      kk = (m < t) ? m : t;
      if (kk > HUE_ONE) kk = HUE_ONE;
    end
    return kk[KW-1:0];
  endfunction

  function automatic chan_t chan_value(input chan_t vmax, input chan_t d, input kval_t k);
    logic [CHANNEL_BITS+KW-1:0] prod;
    prod = {{KW{1'b0}}, d} * {{CHANNEL_BITS{1'b0}}, k};
    return vmax - CHANNEL_BITS'(prod >> HUE_FRACTION_BITS);
  endfunction

  assign g_ready  = !o_v_r || out_ch.ready;
  assign up_ready = !g_v_r || g_ready;

  assign out_ch.valid     = o_v_r;
  assign out_ch.red_out   = red_r;
  assign out_ch.green_out = green_r;
  assign out_ch.blue_out  = blue_r;
  assign out_ch.alpha_out = alpha_r;

  always_comb begin
    g_nxt.alpha = up_data.alpha;
    g_nxt.vmax  = up_data.vmax;
    g_nxt.d     = up_data.d;
    g_nxt.kr    = chan_weight(up_data.hue, OFF_RED);
    g_nxt.kg    = chan_weight(up_data.hue, OFF_GREEN);
    g_nxt.kb    = chan_weight(up_data.hue, OFF_BLUE);
  end

  // A gray pixel has zero chroma, so every channel comes out as the value.
  always_comb begin
    red_nxt   = chan_value(g_r.vmax, g_r.d, g_r.kr);
    green_nxt = chan_value(g_r.vmax, g_r.d, g_r.kg);
    blue_nxt  = chan_value(g_r.vmax, g_r.d, g_r.kb);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      if (up_ready) begin
        g_v_r <= up_valid;
      end
      if (g_ready) begin
        o_v_r <= g_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      g_r <= g_nxt;
    end
    if (g_ready && g_v_r) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
      alpha_r <= g_r.alpha;
    end
  end

endmodule

### hdl/rgb_hue_shift.sv
// Every accepted input transaction yields one result transaction. Throughput: one pixel
// per cycle while out_ch is ready; the eight register stages (analysis, three
// divider slices of three quotient bits each, hue, offset, weight, output) each hold one.
// Each stage stalls on its own, so bubbles close up while the output waits.
// Reset clears all stage valid bits and sets the hue offset to 0.
module rgb_hue_shift import hsh_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [HUE_W-1:0] cfg_data,
  hsh_in_if.sink           in_ch,
  hsh_out_if.source        out_ch
);

  hue_val_t shift_r;
  hue_val_t shift_nxt;

  logic div_v   [DIV_STAGES+1];
  logic div_rdy [DIV_STAGES+1];
  div_t div_d   [DIV_STAGES+1];

  logic hue_v;
  logic hue_rdy;
  hue_t hue_d;

  // Offsets past one turn are folded once at write time.
  assign shift_nxt = (cfg_data >= HUE_TURN) ? (cfg_data - HUE_TURN) : cfg_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= '0;
    end else if (cfg_we) begin
      shift_r <= shift_nxt;
    end
  end

  hsh_analyze u_analyze (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .dn_valid (div_v[0]),
    .dn_ready (div_rdy[0]),
    .dn_data  (div_d[0])
  );

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    hsh_div_stage u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (div_v[s]),
      .up_ready (div_rdy[s]),
      .up_data  (div_d[s]),
      .dn_valid (div_v[s+1]),
      .dn_ready (div_rdy[s+1]),
      .dn_data  (div_d[s+1])
    );
  end

  hsh_hue u_hue (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift    (shift_r),
    .up_valid (div_v[DIV_STAGES]),
    .up_ready (div_rdy[DIV_STAGES]),
    .up_data  (div_d[DIV_STAGES]),
    .dn_valid (hue_v),
    .dn_ready (hue_rdy),
    .dn_data  (hue_d)
  );

  hsh_rebuild u_rebuild (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (hue_v),
    .up_ready (hue_rdy),
    .up_data  (hue_d),
    .out_ch   (out_ch)
  );

endmodule

### tb/sv/tb_rgb_hue_shift.sv
// Self-checking testbench for the RGBA hue rotation pipeline rgb_hue_shift.
module tb_rgb_hue_shift;
  import hsh_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD  = 8;
  localparam int RESET_TICKS = 9;
  localparam int PHASE_ITEMS = 150;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_TICKS = 20;

  // Hue arithmetic in plain integers: one sextant and one full turn.
  localparam int UNIT = 1 << HUE_FRACTION_BITS;
  localparam int TURN = 6 * UNIT;

  localparam hue_val_t SHIFT_ZERO  = '0;
  localparam hue_val_t SHIFT_ONE   = hue_val_t'(1);
  localparam hue_val_t SHIFT_HALF  = hue_val_t'(3 * UNIT);
  localparam hue_val_t SHIFT_MAX   = hue_val_t'(TURN - 1);
  localparam hue_val_t SHIFT_WRAP  = hue_val_t'(TURN);
  localparam hue_val_t SHIFT_TOP   = '1;

  typedef struct packed {
    chan_t r;
    chan_t g;
    chan_t b;
    chan_t a;
  } pixel_t;

  typedef struct packed {
    hue_val_t shift;
    logic     typed;
    pixel_t   px;
    pixel_t   want;
  } dir_row_t;

  localparam int DIR_COUNT = 23;
  localparam dir_row_t DIR_ROWS [DIR_COUNT] = '{
    // Reset offset: gray, black, white and the six pure hues come back as they went in.
    '{SHIFT_ZERO, 1'b1, '{8'd0,   8'd0,   8'd0,   8'd0},   '{8'd0,   8'd0,   8'd0,   8'd0}},
    '{SHIFT_ZERO, 1'b1, '{8'd255, 8'd255, 8'd255, 8'd255}, '{8'd255, 8'd255, 8'd255, 8'd255}},
    '{SHIFT_ZERO, 1'b1, '{8'd128, 8'd128, 8'd128, 8'd90},  '{8'd128, 8'd128, 8'd128, 8'd90}},
    '{SHIFT_ZERO, 1'b1, '{8'd255, 8'd0,   8'd0,   8'd17},  '{8'd255, 8'd0,   8'd0,   8'd17}},
    '{SHIFT_ZERO, 1'b1, '{8'd0,   8'd255, 8'd0,   8'd34},  '{8'd0,   8'd255, 8'd0,   8'd34}},
    '{SHIFT_ZERO, 1'b1, '{8'd0,   8'd0,   8'd255, 8'd51},  '{8'd0,   8'd0,   8'd255, 8'd51}},
    '{SHIFT_ZERO, 1'b1, '{8'd255, 8'd255, 8'd0,   8'd68},  '{8'd255, 8'd255, 8'd0,   8'd68}},
    '{SHIFT_ZERO, 1'b1, '{8'd0,   8'd255, 8'd255, 8'd85},  '{8'd0,   8'd255, 8'd255, 8'd85}},
    '{SHIFT_ZERO, 1'b1, '{8'd255, 8'd0,   8'd255, 8'd102}, '{8'd255, 8'd0,   8'd255, 8'd102}},
    '{SHIFT_ZERO, 1'b0, '{8'd1,   8'd0,   8'd0,   8'd170}, '0},
    '{SHIFT_ZERO, 1'b0, '{8'd255, 8'd0,   8'd1,   8'd1},   '0},
    '{SHIFT_ZERO, 1'b0, '{8'd255, 8'd254, 8'd0,   8'd254}, '0},
    '{SHIFT_ZERO, 1'b0, '{8'd0,   8'd1,   8'd255, 8'd127}, '0},
    '{SHIFT_ZERO, 1'b0, '{8'd254, 8'd255, 8'd1,   8'd128}, '0},
    '{SHIFT_MAX,  1'b0, '{8'd255, 8'd0,   8'd0,   8'd200}, '0},
    '{SHIFT_MAX,  1'b0, '{8'd10,  8'd200, 8'd90,  8'd3},   '0},
    '{SHIFT_MAX,  1'b1, '{8'd77,  8'd77,  8'd77,  8'd9},   '{8'd77,  8'd77,  8'd77,  8'd9}},
    '{SHIFT_TOP,  1'b0, '{8'd255, 8'd0,   8'd0,   8'd60},  '0},
    '{SHIFT_TOP,  1'b0, '{8'd200, 8'd10,  8'd90,  8'd61},  '0},
    '{SHIFT_TOP,  1'b1, '{8'd0,   8'd0,   8'd0,   8'd255}, '{8'd0,   8'd0,   8'd0,   8'd255}},
    '{SHIFT_WRAP, 1'b0, '{8'd255, 8'd0,   8'd0,   8'd40},  '0},
    '{SHIFT_ONE,  1'b0, '{8'd255, 8'd128, 8'd0,   8'd41},  '0},
    '{SHIFT_HALF, 1'b0, '{8'd255, 8'd0,   8'd0,   8'd42},  '0}
  };

  localparam int PLAN_FIXED = 7;
  localparam int PLAN_COUNT = 10;
  localparam hue_val_t SHIFT_PLAN [PLAN_FIXED] = '{
    SHIFT_ZERO, SHIFT_MAX, SHIFT_TOP, SHIFT_WRAP, SHIFT_ONE, SHIFT_HALF, hue_val_t'(UNIT)
  };

  logic     clk = 1'b0;
  logic     rst_n;
  logic     cfg_we;
  hue_val_t cfg_data;

  hsh_in_if  in_bus ();
  hsh_out_if out_bus ();

  rgb_hue_shift dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_ch    (in_bus),
    .out_ch   (out_bus)
  );

  pixel_t   pending_pixels [$];
  hue_val_t cur_shift = '0;
  bit       src_calm = 1'b0;
  bit       sink_calm = 1'b0;
  int       sink_hold = 0;
  int       err_count = 0;
  int       px_sent = 0;
  int       px_checked = 0;
  int       settings_used = 0;
  int       cycles = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic int floor_div(int num, int den);
    if (num >= 0) return num / den;
    return -((-num + den - 1) / den);
  endfunction

  function automatic int channel_level(int vmax, int d, int hue, int c);
    int m;
    int k;
    m = (c * UNIT + hue) % TURN;
    k = 4 * UNIT - m;
    if (m < k) k = m;
    if (k > UNIT) k = UNIT;
    if (k < 0) k = 0;
    return vmax - (d * k) / UNIT;
  endfunction

  function automatic pixel_t rotate_hue(pixel_t px, hue_val_t shift);
    int r;
    int g;
    int b;
    int vmax;
    int vmin;
    int d;
    int h;
    pixel_t res;
    r = px.r;
    g = px.g;
    b = px.b;
    vmax = r;
    vmin = r;
    if (g > vmax) vmax = g;
    if (b > vmax) vmax = b;
    if (g < vmin) vmin = g;
    if (b < vmin) vmin = b;
    d = vmax - vmin;
    res = px;
    if (d == 0) return res;
    // Sector ties resolve red first, then green.
    if (r == vmax) h = floor_div((g - b) * UNIT, d);
    else if (g == vmax) h = 2 * UNIT + floor_div((b - r) * UNIT, d);
    else h = 4 * UNIT + floor_div((r - g) * UNIT, d);
    if (h < 0) h += TURN;
    h = (h + int'(shift)) % TURN;
    res.r = chan_t'(channel_level(vmax, d, h, 5));
    res.g = chan_t'(channel_level(vmax, d, h, 3));
    res.b = chan_t'(channel_level(vmax, d, h, 1));
    return res;
  endfunction

  function automatic int idle_length();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 75) return $urandom_range(1, 3);
    if (pick < 95) return $urandom_range(4, 8);
    return $urandom_range(9, 24);
  endfunction

  function automatic chan_t rail_level();
    case ($urandom_range(0, 3))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd254;
      default: return 8'd255;
    endcase
  endfunction

  // Uniform pixels mixed with gray, tied channels, near-gray and rail values.
  function automatic pixel_t rand_pixel();
    pixel_t px;
    px.r = chan_t'($urandom_range(0, 255));
    px.g = chan_t'($urandom_range(0, 255));
    px.b = chan_t'($urandom_range(0, 255));
    px.a = chan_t'($urandom_range(0, 255));
    case ($urandom_range(0, 10))
      5: begin
        px.g = px.r;
        px.b = px.r;
      end
      6: px.g = px.r;
      7: px.b = px.g;
      8: px.b = px.r;
      9: begin
        px.g = px.r ^ chan_t'($urandom_range(0, 3));
        px.b = px.r ^ chan_t'($urandom_range(0, 3));
      end
      10: begin
        px.r = rail_level();
        px.g = rail_level();
        px.b = rail_level();
      end
      default: ;
    endcase
    return px;
  endfunction

  task automatic flag_error(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    err_count++;
  endtask

  task automatic send_pixel(pixel_t px, logic typed, pixel_t want);
    int gap;
    gap = (!src_calm && $urandom_range(0, 2) == 0) ? idle_length() : 0;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid    <= 1'b1;
    in_bus.red_in   <= px.r;
    in_bus.green_in <= px.g;
    in_bus.blue_in  <= px.b;
    in_bus.alpha_in <= px.a;
    do @(posedge clk); while (!in_bus.ready);
    pending_pixels.push_back(typed ? want : rotate_hue(px, cur_shift));
    px_sent++;
  endtask

  // Every pixel yields exactly one result, so an empty queue means an empty pipeline.
  task automatic set_shift(hue_val_t value);
    in_bus.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_shift = value;
    settings_used++;
  endtask

  task automatic check_pixel(pixel_t got);
    pixel_t want;
    if (pending_pixels.size() == 0) begin
      flag_error($sformatf("result transaction with nothing pending: %h", got));
    end else begin
      want = pending_pixels.pop_front();
      if (got.r !== want.r)
        flag_error($sformatf("pixel %0d red: got %0d, expected %0d", px_checked, got.r, want.r));
      if (got.g !== want.g)
        flag_error($sformatf("pixel %0d green: got %0d, expected %0d", px_checked, got.g,
                             want.g));
      if (got.b !== want.b)
        flag_error($sformatf("pixel %0d blue: got %0d, expected %0d", px_checked, got.b, want.b));
      if (got.a !== want.a)
        flag_error($sformatf("pixel %0d alpha: got %0d, expected %0d", px_checked, got.a,
                             want.a));
    end
    px_checked++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready)
      check_pixel('{out_bus.red_out, out_bus.green_out, out_bus.blue_out, out_bus.alpha_out});
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else if (sink_hold > 0) begin
      out_bus.ready <= 1'b0;
      sink_hold <= sink_hold - 1;
    end else begin
      out_bus.ready <= 1'b1;
      if (!sink_calm && $urandom_range(0, 3) == 0) sink_hold <= idle_length();
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles, %0d results outstanding", cycles,
               pending_pixels.size());
      $display("rgb_hue_shift regression: fail");
      $finish;
    end
  end

  initial begin
    hue_val_t shift;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_data        = '0;
    in_bus.valid    = 1'b0;
    in_bus.red_in   = '0;
    in_bus.green_in = '0;
    in_bus.blue_in  = '0;
    in_bus.alpha_in = '0;
    out_bus.ready   = 1'b0;
    repeat (RESET_TICKS) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows start on the reset offset, which the first rows confirm.
    for (int i = 0; i < DIR_COUNT; i++) begin
      if (DIR_ROWS[i].shift != cur_shift) set_shift(DIR_ROWS[i].shift);
      send_pixel(DIR_ROWS[i].px, DIR_ROWS[i].typed, DIR_ROWS[i].want);
    end

    for (int p = 0; p < PLAN_COUNT; p++) begin
      shift = (p < PLAN_FIXED) ? SHIFT_PLAN[p] : hue_val_t'($urandom_range(0, 2047));
      set_shift(shift);
      src_calm  = ($urandom_range(0, 3) == 0);
      sink_calm = ($urandom_range(0, 3) == 0);
      repeat (PHASE_ITEMS) send_pixel(rand_pixel(), 1'b0, '0);
    end

    in_bus.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);

    $display("Sent %0d pixels (%0d directed) over %0d hue offset writes;", px_sent, DIR_COUNT,
             settings_used);
    $display("%0d results compared, %0d mismatches.", px_checked, err_count);
    if (err_count == 0) begin
      $display("rgb_hue_shift regression: pass");
    end else begin
      $display("rgb_hue_shift regression: fail");
    end
    $finish;
  end

endmodule
